@@ design/hgm_pkg.sv @@
package hgm_pkg;

  // Result kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_MIN    = 2'd2;
  localparam logic [1:0] KIND_MAX    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE   = 2'd2;

  // Configuration reset values
  localparam logic [12:0] GRID_WIDTH_RST  = 13'd2;
  localparam logic [12:0] GRID_HEIGHT_RST = 13'd2;
  localparam logic [15:0] CELL_SIZE_RST   = 16'd256;

  // Bounds reset values
  localparam logic [27:0]        COORD_MAX = 28'hFFFFFFF;
  localparam logic signed [23:0] ELEV_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] ELEV_MIN  = 24'sh800000;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [27:0]        x;
    logic signed [23:0] y;
    logic [27:0]        z;
  } hgm_point_t;

  // One classified sample, as handed from front to back
  typedef struct packed {
    hgm_point_t  vtx;
    logic [23:0] vnum;
    logic [23:0] v0;
    logic        closes;
    logic        fin;
    hgm_point_t  lo;
    hgm_point_t  hi;
  } hgm_entry_t;

endpackage

@@ design/hgm_front.sv @@
module hgm_front import hgm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] elevation,
  input  logic               q_full,
  output logic               push,
  output hgm_entry_t         entry
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int AW   = CW + 16;
  localparam int EW   = (AW > 28) ? AW : 28;
  localparam int CMPW = (DW > 13) ? DW : 13;
  localparam logic [EW-1:0] SAT = EW'(COORD_MAX);

  logic [12:0]   grid_width;
  logic [12:0]   grid_height;
  logic [15:0]   cell_size;
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [AW-1:0] x_acc;
  logic [AW-1:0] z_acc;
  logic [23:0]   vertex_count;
  hgm_point_t    low;
  hgm_point_t    high;

  logic          accept;
  logic          cfg_hit;
  logic          restart;
  logic [DW-1:0] w;
  logic [DW-1:0] h;
  logic          col_last;
  logic          row_last;
  logic [EW-1:0] x_ext;
  logic [EW-1:0] z_ext;
  hgm_point_t    vtx;
  hgm_point_t    low_next;
  hgm_point_t    high_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  // Clamp grid dimensions to the supported range
  always_comb begin
    if (grid_width < 13'd2) begin
      w = DW'(2);
    end else if (CMPW'(grid_width) > CMPW'(MAX_DIM)) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(grid_width);
    end
    if (grid_height < 13'd2) begin
      h = DW'(2);
    end else if (CMPW'(grid_height) > CMPW'(MAX_DIM)) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(grid_height);
    end
  end

  assign col_last = (DW'(column_count) == w - DW'(1));
  assign row_last = (DW'(row_count) == h - DW'(1));

  // Saturate the running position sums
  assign x_ext = EW'(x_acc);
  assign z_ext = EW'(z_acc);
  always_comb begin
    vtx.x = (x_ext > SAT) ? COORD_MAX : x_ext[27:0];
    vtx.y = elevation;
    vtx.z = (z_ext > SAT) ? COORD_MAX : z_ext[27:0];
  end

  // Fold the new vertex into the bounding box
  always_comb begin
    low_next.x  = (vtx.x < low.x) ? vtx.x : low.x;
    low_next.z  = (vtx.z < low.z) ? vtx.z : low.z;
    low_next.y  = ($signed(vtx.y) < $signed(low.y)) ? vtx.y : low.y;
    high_next.x = (vtx.x > high.x) ? vtx.x : high.x;
    high_next.z = (vtx.z > high.z) ? vtx.z : high.z;
    high_next.y = ($signed(vtx.y) > $signed(high.y)) ? vtx.y : high.y;
  end

  // Classify the transaction for the back end
  always_comb begin
    entry.vtx    = vtx;
    entry.vnum   = vertex_count;
    entry.v0     = vertex_count - 24'(w) - 24'd1;
    entry.closes = (row_count != '0) && (column_count != '0);
    entry.fin    = col_last && row_last;
    entry.lo     = low_next;
    entry.hi     = high_next;
  end

  assign cfg_hit = cfg_write && (cfg_index == REG_GRID_WIDTH ||
                                 cfg_index == REG_GRID_HEIGHT ||
                                 cfg_index == REG_CELL_SIZE);
  assign restart = cfg_hit || (accept && col_last && row_last);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      cell_size   <= CELL_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[12:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[12:0];
        REG_CELL_SIZE:   cell_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance grid position and bounds
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
      x_acc        <= '0;
      z_acc        <= '0;
      vertex_count <= '0;
      low.x        <= COORD_MAX;
      low.y        <= ELEV_MAX;
      low.z        <= COORD_MAX;
      high.x       <= '0;
      high.y       <= ELEV_MIN;
      high.z       <= '0;
    end else if (accept) begin
      vertex_count <= vertex_count + 24'd1;
      low          <= low_next;
      high         <= high_next;
      if (col_last) begin
        column_count <= '0;
        x_acc        <= '0;
        row_count    <= row_count + CW'(1);
        z_acc        <= z_acc + AW'(cell_size);
      end else begin
        column_count <= column_count + CW'(1);
        x_acc        <= x_acc + AW'(cell_size);
      end
    end
  end

endmodule

@@ design/hgm_queue.sv @@
module hgm_queue import hgm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hgm_entry_t din,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output hgm_entry_t dout
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  hgm_entry_t    slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(QDEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/hgm_back.sv @@
module hgm_back import hgm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  hgm_entry_t         head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [27:0]        coord_x,
  output logic signed [23:0] coord_y,
  output logic [27:0]        coord_z,
  output logic [23:0]        vertex_ref,
  output logic               last
);

  typedef enum logic [3:0] {
    S_VTX, S_IDX0, S_IDX1, S_IDX2, S_IDX3, S_IDX4, S_IDX5, S_MIN, S_MAX
  } step_t;

  step_t              step;
  step_t              step_next;
  logic               can_load;
  logic               done;
  logic [1:0]         kind_next;
  hgm_point_t         pt_next;
  logic [23:0]        ref_next;
  logic [23:0]        v1;
  logic [23:0]        v2;

  assign can_load = !out_valid || !out_stall;
  assign pop      = can_load && q_valid && done;
  assign v1       = head.v0 + 24'd1;
  assign v2       = head.vnum - 24'd1;

  // Select the next result of the current entry
  always_comb begin
    kind_next = KIND_INDEX;
    pt_next   = '0;
    ref_next  = '0;
    step_next = S_VTX;
    done      = 1'b0;
    case (step)
      S_VTX: begin
        kind_next = KIND_VERTEX;
        pt_next   = head.vtx;
        ref_next  = head.vnum;
        if (head.closes) begin
          step_next = S_IDX0;
        end else if (head.fin) begin
          step_next = S_MIN;
        end else begin
          done = 1'b1;
        end
      end
      S_IDX0: begin
        ref_next  = head.v0;
        step_next = S_IDX1;
      end
      S_IDX1: begin
        ref_next  = v2;
        step_next = S_IDX2;
      end
      S_IDX2: begin
        ref_next  = v1;
        step_next = S_IDX3;
      end
      S_IDX3: begin
        ref_next  = v1;
        step_next = S_IDX4;
      end
      S_IDX4: begin
        ref_next  = v2;
        step_next = S_IDX5;
      end
      S_IDX5: begin
        ref_next = head.vnum;
        if (head.fin) begin
          step_next = S_MIN;
        end else begin
          done = 1'b1;
        end
      end
      S_MIN: begin
        kind_next = KIND_MIN;
        pt_next   = head.lo;
        step_next = S_MAX;
      end
      S_MAX: begin
        kind_next = KIND_MAX;
        pt_next   = head.hi;
        done      = 1'b1;
      end
      default: begin
        step_next = S_VTX;
      end
    endcase
  end

  // Hold step and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_VTX;
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        step       <= step_next;
        kind       <= kind_next;
        coord_x    <= pt_next.x;
        coord_y    <= pt_next.y;
        coord_z    <= pt_next.z;
        vertex_ref <= ref_next;
        last       <= (step == S_MAX);
      end
    end
  end

endmodule

@@ design/heightmap_grid_mesher.sv @@
// Channel  Handshake              Payload
// cfg      cfg_write              cfg_index, cfg_data
// in       in_valid / in_stall    elevation
// out      out_valid / out_stall  kind, coord_x, coord_y, coord_z, vertex_ref, last
//
// The output register issues one result per cycle while out_stall is low. A sample
// gives a vertex, six indices if it closes a cell, both bounds if it ends a grid.
// Samples enter in back-to-back cycles while the two-entry queue has room.
// Reset is synchronous; all control state clears at once, no clearing pass.
// in_stall rises only when the queue is full; out_stall holds the result steady.
module heightmap_grid_mesher import hgm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] elevation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [27:0]        coord_x,
  output logic signed [23:0] coord_y,
  output logic [27:0]        coord_z,
  output logic [23:0]        vertex_ref,
  output logic               last
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  hgm_entry_t q_din;
  hgm_entry_t q_head;

  // Accept and classify samples
  hgm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .elevation (elevation),
    .q_full    (q_full),
    .push      (q_push),
    .entry     (q_din)
  );

  // Decouple front and back
  hgm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  // Emit vertex, index and bounds results
  hgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .vertex_ref (vertex_ref),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_last_on_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == KIND_MAX)
    else $error("last flag on a result that is not the bounds maximum");

  a_max_follows_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind == KIND_MIN |=> out_valid && kind == KIND_MAX)
    else $error("bounds minimum not followed by bounds maximum");

  a_index_zero_coords: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_INDEX |->
      coord_x == '0 && coord_y == '0 && coord_z == '0 && !last)
    else $error("index transaction carries coordinates");
`endif

endmodule

@@ bench/mesh_result_checker.sv @@
`timescale 1ns / 1ps

module mesh_result_checker import hgm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [23:0] elevation,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         kind,
  input  logic [27:0]        coord_x,
  input  logic signed [23:0] coord_y,
  input  logic [27:0]        coord_z,
  input  logic [23:0]        vertex_ref,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]         kind;
    logic [27:0]        x;
    logic signed [23:0] y;
    logic [27:0]        z;
    logic [23:0]        vref;
    logic               last;
  } mesh_item_t;

  // Expected mesh items, oldest first
  mesh_item_t pending_mesh_items[$];

  // Register copies
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [15:0] cell_reg;

  // Grid walk and bounding box
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic signed [23:0] lo_y;
  logic signed [23:0] hi_y;
  logic [27:0]        lo_x;
  logic [27:0]        hi_x;
  logic [27:0]        lo_z;
  logic [27:0]        hi_z;

  function automatic void restart_grid();
    col_pos = 0;
    row_pos = 0;
    lo_y    = ELEV_MAX;
    hi_y    = ELEV_MIN;
    lo_x    = COORD_MAX;
    hi_x    = '0;
    lo_z    = COORD_MAX;
    hi_z    = '0;
  endfunction

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Saturate position * spacing to Q20.8
  function automatic logic [27:0] scale_coord(input int unsigned n);
    longint unsigned p;
    p = 64'(n);
    p = p * 64'(cell_reg);
    if (p > COORD_MAX) return COORD_MAX;
    return p[27:0];
  endfunction

  function automatic void push_item(input logic [1:0] k, input logic [27:0] x,
                                    input logic signed [23:0] y, input logic [27:0] z,
                                    input logic [23:0] vref, input logic lst);
    mesh_item_t it;
    it.kind = k;
    it.x    = x;
    it.y    = y;
    it.z    = z;
    it.vref = vref;
    it.last = lst;
    pending_mesh_items.insert(pending_mesh_items.size(), it);
  endfunction

  // Work out the vertex, cell indices and bounds caused by one sample
  function automatic void predict_sample(input logic signed [23:0] y);
    int unsigned w;
    int unsigned h;
    int unsigned v0;
    int unsigned v2;
    logic [27:0] x;
    logic [27:0] z;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    x = scale_coord(col_pos);
    z = scale_coord(row_pos);
    push_item(KIND_VERTEX, x, y, z, 24'(row_pos * w + col_pos), 1'b0);

    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (z < lo_z) lo_z = z;
    if (z > hi_z) hi_z = z;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;

    // Close the cell up and to the left
    if (row_pos >= 1 && col_pos >= 1) begin
      v0 = (row_pos - 1) * w + (col_pos - 1);
      v2 = row_pos * w + (col_pos - 1);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v0), 1'b0);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v2), 1'b0);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v0 + 1), 1'b0);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v0 + 1), 1'b0);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v2), 1'b0);
      push_item(KIND_INDEX, '0, '0, '0, 24'(v2 + 1), 1'b0);
    end

    // Advance the walk; emit bounds at the end of the grid
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        push_item(KIND_MIN, lo_x, lo_y, lo_z, '0, 1'b0);
        push_item(KIND_MAX, hi_x, hi_y, hi_z, '0, 1'b1);
        restart_grid();
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    mesh_item_t want;
    if (rst) begin
      width_reg  = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      cell_reg   = CELL_SIZE_RST;
      fail_count = 0;
      restart_grid();
      pending_mesh_items.delete();
    end else begin
      // Any known register write restarts the grid
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_WIDTH: begin
            width_reg = cfg_data[12:0];
            restart_grid();
          end
          REG_GRID_HEIGHT: begin
            height_reg = cfg_data[12:0];
            restart_grid();
          end
          REG_CELL_SIZE: begin
            cell_reg = cfg_data;
            restart_grid();
          end
          default: ;
        endcase
      end

      if (in_valid && !in_stall) predict_sample(elevation);

      // Compare the result transaction with the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_mesh_items.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d ref %0h",
                   $time, kind, vertex_ref);
          fail_count++;
        end else begin
          want = pending_mesh_items.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("coord_x", 32'(want.x), 32'(coord_x));
          check_field("coord_y", 32'(want.y), 32'(coord_y));
          check_field("coord_z", 32'(want.z), 32'(coord_z));
          check_field("vertex_ref", 32'(want.vref), 32'(vertex_ref));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
    pending = pending_mesh_items.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import hgm_pkg::*;;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_PAD        = 8;
  localparam int BIG_ROW_SAMPLES  = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] elevation = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [27:0]        coord_x;
  logic signed [23:0] coord_y;
  logic [27:0]        coord_z;
  logic [23:0]        vertex_ref;
  logic               last;

  int   fail_count;
  int   pending;
  int   tx_gap_pct = 0;
  int   rx_stall_pct = 0;
  logic long_hold = 1'b0;
  event hold_kick;

  int gap_tbl[4]   = '{0, 78, 0, 23};
  int stall_tbl[4] = '{0, 0, 78, 23};

  heightmap_grid_mesher u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .elevation  (elevation),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .vertex_ref (vertex_ref),
    .last       (last)
  );

  mesh_result_checker u_mesh_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .elevation  (elevation),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .vertex_ref (vertex_ref),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random output stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= long_hold || ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    forever begin
      @(hold_kick);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [23:0] rand_elev();
    case ($urandom_range(7))
      0: return ELEV_MIN;
      1: return ELEV_MAX;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one sample; valid stays high after acceptance until the next call
  task automatic send_sample(input logic signed [23:0] e);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    elevation <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic setup_grid(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] spacing);
    drain();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_CELL_SIZE, spacing);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int          w;
    int          h;
    int          n;
    int          cnt;
    int          m;
    int          g;
    logic [15:0] spacing;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default 2x2 grid, elevation extremes
    send_sample(ELEV_MIN);
    send_sample(ELEV_MAX);
    send_sample(24'sd0);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    send_sample(ELEV_MAX);

    // 3x3 grid with zero spacing
    setup_grid(16'd3, 16'd3, 16'd0);
    for (g = 0; g < 9; g++) send_sample(rand_elev());

    // Dimensions below range clamp up; bits above the field are dropped
    setup_grid(16'hE000, 16'd1, 16'hFFFF);
    send_sample(ELEV_MAX);
    send_sample(ELEV_MIN);
    // Write to an unused index mid-grid: the grid must not restart
    drain();
    write_reg(REG_NONE, 16'hFFFF);
    cfg_write <= 1'b0;
    send_sample(24'sd256);
    send_sample(-24'sd256);

    // Hold the receiver off while a full grid is offered
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    setup_grid(16'd6, 16'd5, 16'($urandom));
    -> hold_kick;
    for (g = 0; g < 30; g++) send_sample(rand_elev());

    // Random grids under each idle pattern
    for (m = 0; m < 4; m++) begin
      tx_gap_pct = gap_tbl[m];
      rx_stall_pct <= stall_tbl[m];
      cnt = 0;
      while (cnt < 30) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(2, 6);
        h = $urandom_range(2, 5);
        case ($urandom_range(3))
          0: spacing = 16'd0;
          1: spacing = 16'hFFFF;
          default: spacing = 16'($urandom);
        endcase
        setup_grid(16'(w), 16'(h), spacing);
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(3) == 0) n = $urandom_range(1, w * h - 1);
        for (g = 0; g < n; g++) begin
          if (g == n / 2 && $urandom_range(5) == 0) drain();
          send_sample(rand_elev());
        end
        cnt += n;
      end
    end

    // Widest row at the largest spacing, first samples only
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    setup_grid(16'hFFFF, 16'd2, 16'hFFFF);
    for (g = 0; g < BIG_ROW_SAMPLES; g++) send_sample(rand_elev());

    // Tallest grid, a few rows only
    setup_grid(16'd2, 16'h1FFF, 16'h8001);
    for (g = 0; g < 12; g++) send_sample(rand_elev());

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ heightmap_grid_mesher.f @@
design/hgm_pkg.sv
design/hgm_front.sv
design/hgm_queue.sv
design/hgm_back.sv
design/heightmap_grid_mesher.sv
bench/mesh_result_checker.sv
bench/tb_top.sv
